/* hdl/ppcu_pkg.sv */
// shared types, constants and helper functions for the planar point coordinate unit
// no dependencies; all files but ppcu_ifs refer to this package by scoped names
package ppcu_pkg;

  // parameter defaults
  localparam int unsigned CORDIC_STAGES_DEF = 28;
  localparam int unsigned COORD_WIDTH_DEF   = 32;

  // datapath widths
  localparam int unsigned WW     = 48;  // guarded coordinate width inside the pipeline
  localparam int unsigned ZW     = 33;  // binary angle accumulator width
  localparam int unsigned SW     = 33;  // raw source coordinate width (sum or difference)
  localparam int unsigned GUARD  = 8;   // extra fraction bits carried through the iterations

  // fixed-point constants
  localparam logic signed [31:0] KINV_Q30       = 32'sd652032874;
  localparam logic signed [33:0] RAD_TO_BIN_Q30 = 34'sd2734261102;
  localparam logic signed [31:0] BIN_TO_RAD_Q32 = 32'sd1686629713;
  localparam logic signed [ZW-1:0] QUARTER_TURN = 33'sd1073741824;

  // opcodes
  localparam logic [2:0] OP_ROTATE     = 3'd0;
  localparam logic [2:0] OP_TO_POLAR   = 3'd1;
  localparam logic [2:0] OP_FROM_POLAR = 3'd2;
  localparam logic [2:0] OP_MIDPOINT   = 3'd3;
  localparam logic [2:0] OP_DISTANCE   = 3'd4;
  localparam logic [2:0] OP_SHIFT      = 3'd5;

  // what the iteration stages do with a word
  localparam logic [1:0] MODE_ROT  = 2'd0;
  localparam logic [1:0] MODE_VEC  = 2'd1;
  localparam logic [1:0] MODE_PASS = 2'd2;
  localparam logic [1:0] MODE_ZERO = 2'd3;

  // word travelling through the iteration stages
  typedef struct packed {
    logic                 valid;
    logic [2:0]           op;
    logic [1:0]           mode;
    logic signed [WW-1:0] x;
    logic signed [WW-1:0] y;
    logic signed [ZW-1:0] z;
  } cw_t;

  // arctangent of 2^-i as a binary angle (2^32 is one turn)
  function automatic logic [31:0] atan_bin(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051D;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      5'd31: r = 32'h00000000;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // clamp to a signed range of w bits; msb of the result is the clamp flag
  function automatic logic [32:0] sat_coord(input logic signed [WW-1:0] v,
                                            input int unsigned w);
    logic signed [WW-1:0] hi;
    logic signed [WW-1:0] lo;
    logic [32:0]          r;
    hi = $signed((WW'(1) << (w - 1)) - WW'(1));
    lo = -hi - WW'(1);
    if (v > hi) begin
      r = {1'b1, hi[31:0]};
    end else if (v < lo) begin
      r = {1'b1, lo[31:0]};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

/* hdl/ppcu_ifs.sv */
// valid/ready channel interfaces for the planar point coordinate unit
// depends on nothing; payload widths are the fixed field widths of the block
interface ppcu_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic signed [31:0] angle;

  modport source (output valid, opcode, a_x, a_y, b_x, b_y, angle, input ready);
  modport sink   (input valid, opcode, a_x, a_y, b_x, b_y, angle, output ready);
endinterface

interface ppcu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_x;
  logic signed [31:0] res_y;
  logic               saturated;

  modport source (output valid, res_x, res_y, saturated, input ready);
  modport sink   (input valid, res_x, res_y, saturated, output ready);
endinterface

/* hdl/ppcu_front.sv */
// front end: operand select, gain prescale and angle conversion multiplies, then
// quadrant pre-turn into the first iteration word; uses ppcu_pkg
module ppcu_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [2:0]         opcode,
  input  logic signed [31:0] a_x,
  input  logic signed [31:0] a_y,
  input  logic signed [31:0] b_x,
  input  logic signed [31:0] b_y,
  input  logic signed [31:0] angle,
  output ppcu_pkg::cw_t      word_out
);

  localparam int unsigned SW = ppcu_pkg::SW;
  localparam int unsigned WW = ppcu_pkg::WW;
  localparam int unsigned ZW = ppcu_pkg::ZW;

  // stage a registers
  logic                 a_vld_r;
  logic [2:0]           a_op_r;
  logic signed [SW-1:0] a_srcx_r, a_srcy_r;
  logic signed [63:0]   a_px_r, a_py_r;
  logic signed [65:0]   a_ang_r;

  logic signed [SW-1:0] srcx_nxt, srcy_nxt;
  logic signed [63:0]   px_nxt, py_nxt;
  logic signed [65:0]   ang_nxt;

  // operand select per opcode
  always_comb begin
    unique case (opcode)
      ppcu_pkg::OP_ROTATE, ppcu_pkg::OP_TO_POLAR: begin
        srcx_nxt = SW'(a_x);
        srcy_nxt = SW'(a_y);
      end
      ppcu_pkg::OP_FROM_POLAR: begin
        srcx_nxt = SW'(a_x);
        srcy_nxt = '0;
      end
      ppcu_pkg::OP_DISTANCE: begin
        srcx_nxt = SW'(a_x) - SW'(b_x);
        srcy_nxt = SW'(a_y) - SW'(b_y);
      end
      ppcu_pkg::OP_MIDPOINT, ppcu_pkg::OP_SHIFT: begin
        srcx_nxt = SW'(a_x) + SW'(b_x);
        srcy_nxt = SW'(a_y) + SW'(b_y);
      end
      default: begin
        srcx_nxt = '0;
        srcy_nxt = '0;
      end
    endcase
  end

  // gain prescale and radian to binary angle products
  assign px_nxt  = 64'(srcx_nxt) * 64'(ppcu_pkg::KINV_Q30);
  assign py_nxt  = 64'(srcy_nxt) * 64'(ppcu_pkg::KINV_Q30);
  assign ang_nxt = 66'(angle) * 66'(ppcu_pkg::RAD_TO_BIN_Q30);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_op_r   <= opcode;
      a_srcx_r <= srcx_nxt;
      a_srcy_r <= srcy_nxt;
      a_px_r   <= px_nxt;
      a_py_r   <= py_nxt;
      a_ang_r  <= ang_nxt;
    end
  end

  // stage b: scale down, round the angle, pick a mode and pre-turn
  logic signed [WW-1:0] psx, psy;
  logic signed [65:0]   ang_rnd;
  logic signed [31:0]   zb;
  logic signed [ZW-1:0] zb_w;
  logic                 src_zero;
  ppcu_pkg::cw_t        word_nxt;
  ppcu_pkg::cw_t        word_r;

  assign psx      = WW'(a_px_r >>> (30 - ppcu_pkg::GUARD));
  assign psy      = WW'(a_py_r >>> (30 - ppcu_pkg::GUARD));
  assign ang_rnd  = a_ang_r + (66'sd1 <<< 29);
  assign zb       = $signed(ang_rnd[61:30]);
  assign zb_w     = ZW'(zb);
  assign src_zero = (a_srcx_r == '0) && (a_srcy_r == '0);

  always_comb begin
    word_nxt.valid = a_vld_r;
    word_nxt.op    = a_op_r;
    word_nxt.mode  = ppcu_pkg::MODE_ZERO;
    word_nxt.x     = '0;
    word_nxt.y     = '0;
    word_nxt.z     = '0;
    unique case (a_op_r)
      ppcu_pkg::OP_ROTATE, ppcu_pkg::OP_FROM_POLAR: begin
        word_nxt.mode = ppcu_pkg::MODE_ROT;
        // rotation past a quarter turn starts with a quarter turn
        if (zb_w > ppcu_pkg::QUARTER_TURN) begin
          word_nxt.x = -psy;
          word_nxt.y = psx;
          word_nxt.z = zb_w - ppcu_pkg::QUARTER_TURN;
        end else if (zb_w < -ppcu_pkg::QUARTER_TURN) begin
          word_nxt.x = psy;
          word_nxt.y = -psx;
          word_nxt.z = zb_w + ppcu_pkg::QUARTER_TURN;
        end else begin
          word_nxt.x = psx;
          word_nxt.y = psy;
          word_nxt.z = zb_w;
        end
      end
      ppcu_pkg::OP_TO_POLAR, ppcu_pkg::OP_DISTANCE: begin
        if (!src_zero) begin
          word_nxt.mode = ppcu_pkg::MODE_VEC;
          // left half plane: turn toward the positive x axis first
          if (psx < 0) begin
            if (psy >= 0) begin
              word_nxt.x = psy;
              word_nxt.y = -psx;
              word_nxt.z = ppcu_pkg::QUARTER_TURN;
            end else begin
              word_nxt.x = -psy;
              word_nxt.y = psx;
              word_nxt.z = -ppcu_pkg::QUARTER_TURN;
            end
          end else begin
            word_nxt.x = psx;
            word_nxt.y = psy;
          end
        end
      end
      ppcu_pkg::OP_MIDPOINT: begin
        word_nxt.mode = ppcu_pkg::MODE_PASS;
        word_nxt.x    = WW'(a_srcx_r >>> 1);
        word_nxt.y    = WW'(a_srcy_r >>> 1);
      end
      ppcu_pkg::OP_SHIFT: begin
        word_nxt.mode = ppcu_pkg::MODE_PASS;
        word_nxt.x    = WW'(a_srcx_r);
        word_nxt.y    = WW'(a_srcy_r);
      end
      default: begin
        word_nxt.mode = ppcu_pkg::MODE_ZERO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r.valid <= 1'b0;
    end else if (en) begin
      word_r <= word_nxt;
    end
  end

  assign word_out = word_r;

endmodule

/* hdl/ppcu_cordic_stage.sv */
// one registered cordic micro-rotation, shared by rotation and vectoring words
// uses ppcu_pkg for the word type, mode codes and arctangent table
module ppcu_cordic_stage #(
  parameter int unsigned STAGE = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  ppcu_pkg::cw_t word_in,
  output ppcu_pkg::cw_t word_out
);

  localparam int unsigned ZW = ppcu_pkg::ZW;
  localparam int unsigned WW = ppcu_pkg::WW;
  localparam logic signed [ZW-1:0] ATAN =
    $signed({1'b0, ppcu_pkg::atan_bin(5'(STAGE))});

  logic signed [WW-1:0] dx, dy;
  logic                 ccw;
  ppcu_pkg::cw_t        word_nxt;
  ppcu_pkg::cw_t        word_r;

  assign dx = word_in.y >>> STAGE;
  assign dy = word_in.x >>> STAGE;

  // rotation follows the residual angle, vectoring drives y toward zero
  assign ccw = (word_in.mode == ppcu_pkg::MODE_ROT) ? !word_in.z[ZW-1]
                                                    : word_in.y[WW-1];

  always_comb begin
    word_nxt = word_in;
    if (word_in.mode == ppcu_pkg::MODE_ROT || word_in.mode == ppcu_pkg::MODE_VEC) begin
      if (ccw) begin
        word_nxt.x = word_in.x - dx;
        word_nxt.y = word_in.y + dy;
        word_nxt.z = word_in.z - ATAN;
      end else begin
        word_nxt.x = word_in.x + dx;
        word_nxt.y = word_in.y - dy;
        word_nxt.z = word_in.z + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r.valid <= 1'b0;
    end else if (en) begin
      word_r <= word_nxt;
    end
  end

  assign word_out = word_r;

endmodule

/* hdl/ppcu_back.sv */
// back end: guard bit rounding and angle scaling, then clamp and select into the
// output register; uses ppcu_pkg
module ppcu_back #(
  parameter int unsigned COORD_WIDTH = ppcu_pkg::COORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  ppcu_pkg::cw_t      word_in,
  output logic               out_valid,
  output logic signed [31:0] res_x,
  output logic signed [31:0] res_y,
  output logic               saturated
);

  localparam int unsigned WW   = ppcu_pkg::WW;
  localparam int unsigned SATW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

  // stage 1 registers
  logic                 b_vld_r;
  logic [2:0]           b_op_r;
  logic [1:0]           b_mode_r;
  logic signed [WW-1:0] b_x_r, b_y_r;
  logic signed [65:0]   b_zp_r;

  logic signed [WW-1:0] ugx, ugy;

  // drop guard bits, round half up
  assign ugx = (word_in.x + WW'(1 << (ppcu_pkg::GUARD - 1))) >>> ppcu_pkg::GUARD;
  assign ugy = (word_in.y + WW'(1 << (ppcu_pkg::GUARD - 1))) >>> ppcu_pkg::GUARD;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= word_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_op_r   <= word_in.op;
      b_mode_r <= word_in.mode;
      b_x_r    <= (word_in.mode == ppcu_pkg::MODE_PASS) ? word_in.x : ugx;
      b_y_r    <= (word_in.mode == ppcu_pkg::MODE_PASS) ? word_in.y : ugy;
      b_zp_r   <= 66'(word_in.z) * 66'(ppcu_pkg::BIN_TO_RAD_Q32);
    end
  end

  // stage 2: clamp, polar angle rounding and result select
  logic [32:0]        satx, saty;
  logic signed [65:0] zp_rnd;
  logic signed [31:0] rx_nxt, ry_nxt;
  logic               flag_nxt;
  logic               vld_r;
  logic signed [31:0] rx_r, ry_r;
  logic               sat_r;

  assign satx   = ppcu_pkg::sat_coord(b_x_r, SATW);
  assign saty   = ppcu_pkg::sat_coord(b_y_r, SATW);
  assign zp_rnd = b_zp_r + (66'sd1 <<< 31);

  always_comb begin
    unique case (b_mode_r)
      ppcu_pkg::MODE_ROT, ppcu_pkg::MODE_PASS: begin
        rx_nxt   = $signed(satx[31:0]);
        ry_nxt   = $signed(saty[31:0]);
        flag_nxt = satx[32] | saty[32];
      end
      ppcu_pkg::MODE_VEC: begin
        rx_nxt   = $signed(satx[31:0]);
        ry_nxt   = (b_op_r == ppcu_pkg::OP_TO_POLAR) ? $signed(zp_rnd[63:32]) : '0;
        flag_nxt = satx[32];
      end
      default: begin
        rx_nxt   = '0;
        ry_nxt   = '0;
        flag_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r  <= rx_nxt;
      ry_r  <= ry_nxt;
      sat_r <= flag_nxt;
    end
  end

  assign out_valid = vld_r;
  assign res_x     = rx_r;
  assign res_y     = ry_r;
  assign saturated = sat_r;

endmodule

/* hdl/planar_point_coordinate_unit.sv */
// planar point coordinate unit: rotate, polar conversion, midpoint, distance, shift
// top level; uses ppcu_pkg, ppcu_ifs, ppcu_front, ppcu_cordic_stage, ppcu_back
//
// words arrive on in_ch (opcode, points a and b in Q16.16, angle in Q4.28) and
// leave on out_ch (res_x, res_y, saturated), both valid/ready channels.
// the pipeline is two front stages for the multiplies and pre-turn, one
// register per micro-rotation and two back stages for rounding, clamping
// and the output register. throughput is one word per cycle unless out_ch
// stalls; every stage holds one word.
// in_ch.ready is high whenever the output register is empty or being drained;
// when the receiver holds out_ch.ready low with a word waiting, the whole
// pipeline freezes in place and nothing is dropped or repeated.
// synchronous reset clears every stage valid bit and holds in_ch.ready low;
// the first word can be taken as soon as rst_n is high.
module planar_point_coordinate_unit #(
  parameter int unsigned CORDIC_STAGES = ppcu_pkg::CORDIC_STAGES_DEF,
  parameter int unsigned COORD_WIDTH   = ppcu_pkg::COORD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ppcu_in_if.sink     in_ch,
  ppcu_out_if.source  out_ch
);

  localparam int unsigned SATW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam logic signed [31:0] SAT_HI = 32'((64'd1 << (SATW - 1)) - 64'd1);
  localparam logic signed [31:0] SAT_LO = -SAT_HI - 32'sd1;

  logic          en;
  logic          out_valid;
  ppcu_pkg::cw_t chain [CORDIC_STAGES+1];

  // global advance: output register empty or being taken
  assign en          = !out_valid || out_ch.ready;
  assign in_ch.ready = en && rst_n;

  ppcu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_ch.valid),
    .opcode   (in_ch.opcode),
    .a_x      (in_ch.a_x),
    .a_y      (in_ch.a_y),
    .b_x      (in_ch.b_x),
    .b_y      (in_ch.b_y),
    .angle    (in_ch.angle),
    .word_out (chain[0])
  );

  // micro-rotation chain
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    ppcu_cordic_stage #(
      .STAGE (g)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .word_in  (chain[g]),
      .word_out (chain[g+1])
    );
  end

  ppcu_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .word_in   (chain[CORDIC_STAGES]),
    .out_valid (out_valid),
    .res_x     (out_ch.res_x),
    .res_y     (out_ch.res_y),
    .saturated (out_ch.saturated)
  );

  assign out_ch.valid = out_valid;

  // a clamped result sits at a range limit
  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.saturated |->
      out_ch.res_x == SAT_HI || out_ch.res_x == SAT_LO ||
      out_ch.res_y == SAT_HI || out_ch.res_y == SAT_LO)
    else $error("saturated result not at a range limit");

  // a waiting word blocks new input
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted while output stalled");

  // reset empties the pipeline
  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid right after reset");

endmodule
